/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is ignored while reset is held.
`define PTG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PTG_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ptg_pkg.sv */
package ptg_pkg;

  localparam int GenW   = 32;
  localparam int TimeW  = 64;
  localparam int DelayW = 32;

  typedef enum logic [1:0] {
    ACT_RESET_START = 2'd0,
    ACT_SELFID_DONE = 2'd1,
    ACT_CHECK_GATE  = 2'd2,
    ACT_CHECK_BM    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    GS_CLOSED     = 2'd0,
    GS_OPEN       = 2'd1,
    GS_EXPIRED    = 2'd2,
    GS_SUPPRESSED = 2'd3
  } gate_state_t;

  typedef enum logic [1:0] {
    GATE_INCUMBENT    = 2'd0,
    GATE_NONINCUMBENT = 2'd1,
    GATE_IRM          = 2'd2,
    GATE_ISO          = 2'd3
  } gate_sel_t;

  typedef enum logic [1:0] {
    CLS_INCUMBENT    = 2'd0,
    CLS_NONINCUMBENT = 2'd1,
    CLS_NONE         = 2'd2
  } cand_class_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_BM_NONINC_DELAY = 2'd0;
  localparam logic [1:0] REG_IRM_DELAY       = 2'd1;
  localparam logic [1:0] REG_ISO_DELAY       = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [GenW-1:0]  generation;
    logic [TimeW-1:0] anchor_time;
    logic [TimeW-1:0] noninc_open;
    logic [TimeW-1:0] irm_open;
    logic [TimeW-1:0] iso_open;
  } anchor_t;

  typedef struct packed {
    logic [GenW-1:0]  generation;
    logic [TimeW-1:0] now;
    gate_sel_t        sel;
    logic             suppress;
  } query_t;

  typedef struct packed {
    gate_state_t      gate_state;
    logic             allowed;
    logic [TimeW-1:0] remaining;
    logic [TimeW-1:0] age;
    logic [TimeW-1:0] anchor;
    logic [TimeW-1:0] allowed_at;
  } result_t;

endpackage

/* rtl/core/post_reset_timing_gate.sv */
// Path: a beat accepted into the input register has its result written to the
//   output register as it leaves, and the result is held there until taken.
// Throughput: one beat per cycle, held back only when the output register is
//   full and out_tready is low; events that give no result never wait on it.
// Reset: rst_n is synchronous and active low; it clears the anchor, all open
//   times and both valid flags and loads the delay registers with defaults.
module post_reset_timing_gate (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // [31:0] generation, [95:32] time_ns
  input  logic [5:0]   in_tuser,   // [1:0] action, [3:2] gate_select, [5:4] candidate_class
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata,  // [63:0] remaining_ns, [127:64] age_ns,
                                   // [191:128] anchor_ns, [255:192] allowed_at_ns
  output logic [2:0]   out_tuser,  // [1:0] gate_state, [2] allowed
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // The design is two register stages. The input register holds the beat
  // that is being worked on; in that cycle the event updates the anchor
  // state or the query is evaluated against it, and a query result lands in
  // the output register. Because the state is updated as the beat leaves the
  // input register, the next beat always sees the effect of the one before.

  localparam logic [ptg_pkg::DelayW-1:0] BmDelayReset  = 32'd125000000;
  localparam logic [ptg_pkg::DelayW-1:0] IrmDelayReset = 32'd625000000;
  localparam logic [ptg_pkg::DelayW-1:0] IsoDelayReset = 32'd1000000000;

  // Configuration registers. Writes are always taken; an index past the last
  // register is simply dropped.
  logic [ptg_pkg::DelayW-1:0] bm_delay_r, bm_delay_nxt;
  logic [ptg_pkg::DelayW-1:0] irm_delay_r, irm_delay_nxt;
  logic [ptg_pkg::DelayW-1:0] iso_delay_r, iso_delay_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    bm_delay_nxt  = bm_delay_r;
    irm_delay_nxt = irm_delay_r;
    iso_delay_nxt = iso_delay_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ptg_pkg::REG_BM_NONINC_DELAY: bm_delay_nxt  = cfg_data;
        ptg_pkg::REG_IRM_DELAY:       irm_delay_nxt = cfg_data;
        ptg_pkg::REG_ISO_DELAY:       iso_delay_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_delay_r  <= BmDelayReset;
      irm_delay_r <= IrmDelayReset;
      iso_delay_r <= IsoDelayReset;
    end else begin
      bm_delay_r  <= bm_delay_nxt;
      irm_delay_r <= irm_delay_nxt;
      iso_delay_r <= iso_delay_nxt;
    end
  end

  // Input register.
  logic                       s1_valid_r, s1_valid_nxt;
  ptg_pkg::action_t           s1_action_r;
  logic [ptg_pkg::GenW-1:0]   s1_gen_r;
  logic [ptg_pkg::TimeW-1:0]  s1_time_r;
  logic [1:0]                 s1_sel_r;
  logic [1:0]                 s1_cls_r;

  logic s1_has_result;
  logic s1_adv;
  logic in_beat;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  ptg_pkg::result_t out_result_r;

  assign s1_has_result = (s1_action_r == ptg_pkg::ACT_CHECK_GATE) ||
                         (s1_action_r == ptg_pkg::ACT_CHECK_BM);
  // A beat leaves the input register when it makes no result or when the
  // output register is empty or being drained in this cycle.
  assign s1_adv    = s1_valid_r && (!s1_has_result || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_action_r <= ptg_pkg::action_t'(in_tuser[1:0]);
      s1_sel_r    <= in_tuser[3:2];
      s1_cls_r    <= in_tuser[5:4];
      s1_gen_r    <= in_tdata[31:0];
      s1_time_r   <= in_tdata[95:32];
    end
  end

  // Map the query onto a gate. A bus-manager check picks the gate from the
  // candidate class; anything other than incumbent or non-incumbent is
  // treated as a node that is not a candidate.
  ptg_pkg::query_t query;

  always_comb begin
    query.generation = s1_gen_r;
    query.now        = s1_time_r;
    query.sel        = ptg_pkg::GATE_INCUMBENT;
    query.suppress   = 1'b0;
    unique case (s1_action_r)
      ptg_pkg::ACT_CHECK_GATE: begin
        query.sel = ptg_pkg::gate_sel_t'(s1_sel_r);
      end
      ptg_pkg::ACT_CHECK_BM: begin
        unique case (s1_cls_r)
          ptg_pkg::CLS_INCUMBENT:    query.sel = ptg_pkg::GATE_INCUMBENT;
          ptg_pkg::CLS_NONINCUMBENT: query.sel = ptg_pkg::GATE_NONINCUMBENT;
          default: begin
            query.sel      = ptg_pkg::GATE_NONINCUMBENT;
            query.suppress = 1'b1;
          end
        endcase
      end
      ptg_pkg::ACT_RESET_START, ptg_pkg::ACT_SELFID_DONE: ;
    endcase
  end

  // Anchor state.
  ptg_pkg::anchor_t anchor_r, anchor_nxt;

  always_comb begin
    anchor_nxt = anchor_r;
    if (s1_adv) begin
      unique case (s1_action_r)
        ptg_pkg::ACT_RESET_START: begin
          // The anchor is dropped, but the generation is taken from the reset event.
          anchor_nxt            = '0;
          anchor_nxt.generation = s1_gen_r;
        end
        ptg_pkg::ACT_SELFID_DONE: begin
          // Open times wrap modulo 2^64 but are compared as plain unsigned values.
          anchor_nxt.valid       = 1'b1;
          anchor_nxt.generation  = s1_gen_r;
          anchor_nxt.anchor_time = s1_time_r;
          anchor_nxt.noninc_open = s1_time_r + {32'd0, bm_delay_r};
          anchor_nxt.irm_open    = s1_time_r + {32'd0, irm_delay_r};
          anchor_nxt.iso_open    = s1_time_r + {32'd0, iso_delay_r};
        end
        ptg_pkg::ACT_CHECK_GATE, ptg_pkg::ACT_CHECK_BM: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
    end else begin
      anchor_r <= anchor_nxt;
    end
  end

  ptg_pkg::result_t eval_result;

  ptg_eval u_eval (
    .anchor_i (anchor_r),
    .query_i  (query),
    .result_o (eval_result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_result) begin
      out_result_r <= eval_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_result_r.allowed_at, out_result_r.anchor,
                       out_result_r.age, out_result_r.remaining};
  assign out_tuser  = {out_result_r.allowed, out_result_r.gate_state};

endmodule

/* rtl/core/ptg_eval.sv */
// Evaluates one gate query against the stored anchor.
module ptg_eval (
  input  ptg_pkg::anchor_t anchor_i,
  input  ptg_pkg::query_t  query_i,
  output ptg_pkg::result_t result_o
);

  logic [ptg_pkg::TimeW-1:0] open_time;

  always_comb begin
    unique case (query_i.sel)
      ptg_pkg::GATE_INCUMBENT:    open_time = anchor_i.anchor_time;
      ptg_pkg::GATE_NONINCUMBENT: open_time = anchor_i.noninc_open;
      ptg_pkg::GATE_IRM:          open_time = anchor_i.irm_open;
      default:                    open_time = anchor_i.iso_open;
    endcase
  end

  always_comb begin
    result_o            = '0;
    result_o.gate_state = ptg_pkg::GS_CLOSED;
    if (anchor_i.valid) begin
      result_o.anchor = anchor_i.anchor_time;
      if (query_i.generation != anchor_i.generation) begin
        result_o.gate_state = ptg_pkg::GS_EXPIRED;
      end else begin
        result_o.allowed_at = open_time;
        if (query_i.now >= anchor_i.anchor_time) begin
          result_o.age = query_i.now - anchor_i.anchor_time;
        end
        if (query_i.now >= open_time) begin
          result_o.gate_state = ptg_pkg::GS_OPEN;
          result_o.allowed    = 1'b1;
        end else begin
          result_o.remaining = open_time - query_i.now;
        end
      end
    end
    // A node that is not a candidate keeps the timing fields but never passes.
    if (query_i.suppress) begin
      result_o.gate_state = ptg_pkg::GS_SUPPRESSED;
      result_o.allowed    = 1'b0;
    end
  end

endmodule

/* rtl/core/ptg_checker.sv */
`include "assert_macros.svh"

module ptg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata,
  input logic [2:0]   out_tuser
);

  `PTG_ASSERT_RST(a_no_result_after_reset, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  `PTG_ASSERT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  `PTG_ASSERT(a_allowed_iff_open, clk, rst_n, out_tvalid |-> (out_tuser[2] == (out_tuser[1:0] == ptg_pkg::GS_OPEN)), "allowed does not match open state")

  `PTG_ASSERT(a_expired_zeros, clk, rst_n, out_tvalid && out_tuser[1:0] == ptg_pkg::GS_EXPIRED |-> out_tdata[127:0] == 128'd0 && out_tdata[255:192] == 64'd0, "expired result carries timing")

endmodule

bind post_reset_timing_gate ptg_checker u_ptg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
